// ===== rtl/itoa_pkg.sv =====
// Shared constants, command and status types for the integer to ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   localparam int VALUE_W     = 64;
   localparam int DIGIT_SLOTS = 20;
   localparam int MAX_DIGITS  = 20;
   localparam int POS_W       = $clog2(DIGIT_SLOTS);
   localparam int COUNT_W     = POS_W + 1;
   localparam int SHIFT_W     = $clog2(VALUE_W);
   localparam int HEX_DIGITS  = VALUE_W / 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ALPHA = 8'h41;

   typedef enum logic [1:0] {
      SEL_DIGIT,
      SEL_SIGN,
      SEL_NUL,
      SEL_OVF
   } out_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        dd_step;
      logic        scan_dec;
      logic        pos_dec;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic hex;
      logic neg;
      logic conv_last;
      logic scan_stop;
      logic too_big;
      logic pos_zero;
      logic out_free;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CH_ZERO + {4'd0, d};
      end else begin
         r = CH_ALPHA + {4'd0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_converter.sv =====
// Top level: 64-bit integer to decimal or hex ASCII string, emitted one character at a time.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   req     | in        | req_valid, req_stall, req_value, req_is_signed,
//           |           | req_base_hex, req_buf_size
//   rsp     | out       | rsp_valid, rsp_stall, rsp_ch, rsp_last, rsp_overflow
//
// Decimal items take a load, the shift-add-3 loop over all 64 input bits and the scan,
// then one character per cycle while rsp_stall is low; hex items skip the shift loop.
// The scan walks the digit store from the top down to find the leading digit.
// Reset is synchronous; the block takes a new item only when the previous one is done.
// A stalled result holds in the output register and halts character output.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_converter
   import itoa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic               req_is_signed,
   input  wire logic               req_base_hex,
   input  wire logic [7:0]         req_buf_size,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_ch,
   output logic                    rsp_last,
   output logic                    rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itoa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_base_hex  (req_base_hex),
      .req_buf_size  (req_buf_size),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ch        (rsp_ch),
      .rsp_last      (rsp_last),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

`default_nettype wire

// ===== rtl/itoa_datapath.sv =====
// Datapath: magnitude, shift-add-3 conversion, digit store, scan pointer and output register.
`timescale 1ns / 1ps
`default_nettype none

module itoa_datapath
   import itoa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic                req_is_signed,
   input  wire logic                req_base_hex,
   input  wire logic [7:0]          req_buf_size,
   input  wire cmd_type             cmd,
   output status_type              status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_ch,
   output logic                     rsp_last,
   output logic                     rsp_overflow
);

   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [3:0]         dig_ff [DIGIT_SLOTS];
   logic [3:0]         dig_in [DIGIT_SLOTS];
   logic [3:0]         adj    [DIGIT_SLOTS];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [SHIFT_W-1:0] cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               sgn_ff, sgn_in;
   logic               hex_ff, hex_in;
   logic               zero_ff, zero_in;
   logic [7:0]         cap_ff, cap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         ch_ff, ch_in;
   logic               last_ff, last_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] n_digits;
   logic [7:0]         need;
   logic               neg_req;

   assign neg_req = req_is_signed & req_value[VALUE_W-1];

   always_comb begin
      mag_in  = mag_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      sgn_in  = sgn_ff;
      hex_in  = hex_ff;
      zero_in = zero_ff;
      cap_in  = cap_ff;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         adj[i]    = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];
         dig_in[i] = dig_ff[i];
      end
      if (cmd.load_in) begin
         mag_in  = neg_req ? (~req_value) + {{(VALUE_W-1){1'b0}}, 1'b1} : req_value;
         neg_in  = neg_req;
         sgn_in  = req_is_signed;
         hex_in  = req_base_hex;
         zero_in = (req_value == '0);
         cap_in  = req_buf_size;
         cnt_in  = '0;
         pos_in  = POS_W'(DIGIT_SLOTS - 1);
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            dig_in[i] = 4'd0;
         end
         if (req_base_hex) begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
               dig_in[i] = mag_in[i*4 +: 4];
            end
         end
      end else if (cmd.dd_step) begin
         dig_in[0] = {adj[0][2:0], mag_ff[VALUE_W-1]};
         for (int i = 1; i < DIGIT_SLOTS; i++) begin
            dig_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + SHIFT_W'(1);
      end
      if (cmd.scan_dec || cmd.pos_dec) begin
         pos_in = pos_ff - POS_W'(1);
      end
   end

   assign n_digits = {1'b0, pos_ff} + COUNT_W'(1);
   assign need     = {{(8-COUNT_W){1'b0}}, n_digits} + (sgn_ff ? 8'd2 : 8'd1);

   always_comb begin
      status.hex       = hex_ff;
      status.neg       = neg_ff;
      status.conv_last = (cnt_ff == {SHIFT_W{1'b1}});
      status.scan_stop = (dig_ff[pos_ff] != 4'd0) || (pos_ff == '0);
      status.too_big   = !zero_ff &&
                         ((n_digits > COUNT_W'(MAX_DIGITS)) || (cap_ff < need));
      status.pos_zero  = (pos_ff == '0);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ch_in        = ch_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.out_sel)
            SEL_DIGIT: begin
               ch_in   = hex_char(dig_ff[pos_ff]);
               last_in = 1'b0;
               ovf_in  = 1'b0;
            end
            SEL_SIGN: begin
               ch_in   = CH_MINUS;
               last_in = 1'b0;
               ovf_in  = 1'b0;
            end
            SEL_NUL: begin
               ch_in   = CH_NUL;
               last_in = 1'b1;
               ovf_in  = 1'b0;
            end
            SEL_OVF: begin
               ch_in   = CH_NUL;
               last_in = 1'b1;
               ovf_in  = 1'b1;
            end
            default: begin
               ch_in   = CH_NUL;
               last_in = 1'b1;
               ovf_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sgn_ff  <= sgn_in;
      hex_ff  <= hex_in;
      zero_ff <= zero_in;
      cap_ff  <= cap_in;
      ch_ff   <= ch_in;
      last_ff <= last_in;
      ovf_ff  <= ovf_in;
      for (int i = 0; i < DIGIT_SLOTS; i++) begin
         dig_ff[i] <= dig_in[i];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ch       = ch_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/itoa_ctrl.sv =====
// Controller state machine: sequences load, conversion, digit scan and character output.
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl
   import itoa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_OVF,
      ST_SIGN,
      ST_DIGITS,
      ST_TERM
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load_in  = 1'b0;
      cmd.dd_step  = 1'b0;
      cmd.scan_dec = 1'b0;
      cmd.pos_dec  = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_sel  = SEL_NUL;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            if (status.hex) begin
               state_in = ST_SCAN;
            end else begin
               cmd.dd_step = 1'b1;
               if (status.conv_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_stop) begin
               if (status.too_big) begin
                  state_in = ST_OVF;
               end else if (status.neg) begin
                  state_in = ST_SIGN;
               end else begin
                  state_in = ST_DIGITS;
               end
            end else begin
               cmd.scan_dec = 1'b1;
            end
         end
         ST_OVF: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_OVF;
               state_in     = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_SIGN;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_DIGIT;
               if (status.pos_zero) begin
                  state_in = ST_TERM;
               end else begin
                  cmd.pos_dec = 1'b1;
               end
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_NUL;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
